@@ rtl/spsq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsq_pkg
// Shared types and constants for the strict-priority send queue scheduler.
// ----------------------------------------------------------------------------
package spsq_pkg;

    localparam int NUM_LEVELS  = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int MEM_DEPTH   = NUM_LEVELS * QUEUE_DEPTH;

    localparam int LVL_W  = 2;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(MEM_DEPTH);
    localparam int ID_W   = 16;

    // Request types
    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_OFFER   = 2'd1;
    localparam logic [1:0] REQ_OUTCOME = 2'd2;

    // Send outcomes
    localparam logic [1:0] OUT_DONE    = 2'd0;
    localparam logic [1:0] OUT_PARTIAL = 2'd1;

    // Result status codes
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_GRANT    = 3'd2;
    localparam logic [2:0] ST_IDLE     = 3'd3;
    localparam logic [2:0] ST_RETRY    = 3'd4;
    localparam logic [2:0] ST_ERROR    = 3'd5;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [ID_W-1:0] package_id;
        logic [1:0]      priority_req;
        logic [1:0]      send_outcome;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [ID_W-1:0]  granted_id;
        logic [LVL_W-1:0] granted_level;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

endpackage

@@ rtl/strict_priority_send_queues_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_send_queues_top
// Strict-priority scheduler over four FIFOs of 16-bit package identifiers.
// ----------------------------------------------------------------------------
// A transaction is taken at the rising edge where start is high and busy is
// low. busy then stays high through the execute and response states, and the
// block answers every transaction with exactly one result: result_valid is
// high in the response state only, and result must be captured then, as the
// receiver cannot hold it off. A new transaction may be started in the cycle
// after the result, so the block takes no new transaction before it has
// answered the last one. Pointers, counts, result fields and the head
// identifier from the shared queue memory's read port all register together.
// Enqueue pushes package_id into the FIFO of priority_req (level 0 highest),
// or answers full. A send offer grants the head of the remembered partial
// level if that FIFO holds anything, otherwise the head of the highest
// non-empty level, otherwise answers idle. An outcome report for the
// outstanding grant pops it and offers again (done), remembers the level and
// answers retry wait with the head left in place (partial), or answers error.
// granted_id and granted_level read as zero except on grant and retry wait.
// No clearing pass is needed after reset: only written entries reach granted_id.
// ----------------------------------------------------------------------------
module strict_priority_send_queues_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  spsq_pkg::req_t  request,
    output logic            result_valid,
    output spsq_pkg::rsp_t  result
);

    spsq_pkg::ctl_cmd_t cmd;

    // Sequence each transaction: capture, execute, present
    spsq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    // Hold the queues and scheduling state, form the result
    spsq_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .result  (result)
    );

endmodule

@@ rtl/spsq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsq_ctrl
// Sequencer: capture a transaction, execute it, present the result.
// ----------------------------------------------------------------------------
module spsq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                result_valid,
    output spsq_pkg::ctl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:  state_next = S_RESP;
            S_RESP:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_RESP);
    assign cmd.load     = (state_reg == S_IDLE) && start;
    assign cmd.exec     = (state_reg == S_EXEC);

endmodule

@@ rtl/spsq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsq_datapath
// Queue memory, per-level pointers and counts, resume and grant tracking.
// ----------------------------------------------------------------------------
module spsq_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  spsq_pkg::ctl_cmd_t  cmd,
    input  spsq_pkg::req_t      request,
    output spsq_pkg::rsp_t      result
);

    spsq_pkg::req_t req_reg;

    logic [spsq_pkg::PTR_W-1:0] head_reg [spsq_pkg::NUM_LEVELS];
    logic [spsq_pkg::PTR_W-1:0] head_next [spsq_pkg::NUM_LEVELS];
    logic [spsq_pkg::PTR_W-1:0] tail_reg [spsq_pkg::NUM_LEVELS];
    logic [spsq_pkg::PTR_W-1:0] tail_next [spsq_pkg::NUM_LEVELS];
    logic [spsq_pkg::CNT_W-1:0] cnt_reg [spsq_pkg::NUM_LEVELS];
    logic [spsq_pkg::CNT_W-1:0] cnt_next [spsq_pkg::NUM_LEVELS];

    logic                       resume_valid_reg;
    logic                       resume_valid_next;
    logic [spsq_pkg::LVL_W-1:0] resume_level_reg;
    logic [spsq_pkg::LVL_W-1:0] resume_level_next;
    logic                       grant_valid_reg;
    logic                       grant_valid_next;
    logic [spsq_pkg::LVL_W-1:0] grant_level_reg;
    logic [spsq_pkg::LVL_W-1:0] grant_level_next;

    logic [2:0]                 status_reg;
    logic [2:0]                 status_next;
    logic [spsq_pkg::LVL_W-1:0] level_reg;
    logic [spsq_pkg::LVL_W-1:0] level_next;
    logic                       use_id_reg;
    logic                       use_id_next;

    logic [spsq_pkg::ID_W-1:0]  mem [spsq_pkg::MEM_DEPTH];
    logic [spsq_pkg::ID_W-1:0]  rd_data_reg;
    logic                       mem_we;
    logic [spsq_pkg::ADDR_W-1:0] mem_waddr;
    logic [spsq_pkg::ADDR_W-1:0] mem_raddr;

    function automatic logic [spsq_pkg::PTR_W-1:0] next_ptr(
        input logic [spsq_pkg::PTR_W-1:0] p
    );
        return (p == spsq_pkg::PTR_W'(spsq_pkg::QUEUE_DEPTH - 1)) ?
               '0 : p + spsq_pkg::PTR_W'(1);
    endfunction

    function automatic logic [spsq_pkg::ADDR_W-1:0] addr_of(
        input logic [spsq_pkg::LVL_W-1:0] lvl,
        input logic [spsq_pkg::PTR_W-1:0] ptr
    );
        return spsq_pkg::ADDR_W'(lvl) * spsq_pkg::ADDR_W'(spsq_pkg::QUEUE_DEPTH)
               + spsq_pkg::ADDR_W'(ptr);
    endfunction

    logic [spsq_pkg::CNT_W-1:0] eff_cnt [spsq_pkg::NUM_LEVELS];
    logic [spsq_pkg::PTR_W-1:0] eff_head [spsq_pkg::NUM_LEVELS];
    logic                       eff_rv;
    logic                       do_offer;
    logic                       found;
    logic [spsq_pkg::LVL_W-1:0] sel;
    logic [spsq_pkg::LVL_W-1:0] rd_lvl;
    logic [spsq_pkg::LVL_W-1:0] prio;
    logic [spsq_pkg::LVL_W-1:0] gl;
    logic                       prio_ok;

    always_comb
    begin
        prio              = req_reg.priority_req;
        gl                = grant_level_reg;
        prio_ok           = (32'(prio) < spsq_pkg::NUM_LEVELS);
        head_next         = head_reg;
        tail_next         = tail_reg;
        cnt_next          = cnt_reg;
        resume_valid_next = resume_valid_reg;
        resume_level_next = resume_level_reg;
        grant_valid_next  = grant_valid_reg;
        grant_level_next  = grant_level_reg;
        status_next       = spsq_pkg::ST_ERROR;
        level_next        = '0;
        use_id_next       = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = addr_of(prio, tail_reg[prio]);
        rd_lvl            = gl;
        eff_rv            = resume_valid_reg;
        do_offer          = 1'b0;
        found             = 1'b0;
        sel               = '0;

        case (req_reg.req_type)
            spsq_pkg::REQ_ENQUEUE:
            begin
                if (prio_ok)
                begin
                    if (cnt_reg[prio] >= spsq_pkg::CNT_W'(spsq_pkg::QUEUE_DEPTH))
                    begin
                        status_next = spsq_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        tail_next[prio] = next_ptr(tail_reg[prio]);
                        cnt_next[prio]  = cnt_reg[prio] + spsq_pkg::CNT_W'(1);
                        status_next     = spsq_pkg::ST_ACCEPTED;
                    end
                end
            end
            spsq_pkg::REQ_OFFER:
            begin
                do_offer = 1'b1;
            end
            spsq_pkg::REQ_OUTCOME:
            begin
                if (grant_valid_reg && (cnt_reg[gl] != '0))
                begin
                    case (req_reg.send_outcome)
                        spsq_pkg::OUT_DONE:
                        begin
                            // pop the granted head, then offer again
                            head_next[gl]     = next_ptr(head_reg[gl]);
                            cnt_next[gl]      = cnt_reg[gl] - spsq_pkg::CNT_W'(1);
                            resume_valid_next = 1'b0;
                            grant_valid_next  = 1'b0;
                            eff_rv            = 1'b0;
                            do_offer          = 1'b1;
                        end
                        spsq_pkg::OUT_PARTIAL:
                        begin
                            resume_valid_next = 1'b1;
                            resume_level_next = gl;
                            grant_valid_next  = 1'b0;
                            status_next       = spsq_pkg::ST_RETRY;
                            level_next        = gl;
                            use_id_next       = 1'b1;
                        end
                        default:
                        begin
                            status_next = spsq_pkg::ST_ERROR;
                        end
                    endcase
                end
            end
            default:
            begin
                status_next = spsq_pkg::ST_ERROR;
            end
        endcase

        eff_cnt  = cnt_next;
        eff_head = head_next;

        if (do_offer)
        begin
            if (eff_rv && (eff_cnt[resume_level_reg] != '0))
            begin
                found = 1'b1;
                sel   = resume_level_reg;
            end
            else
            begin
                if (eff_rv)
                begin
                    resume_valid_next = 1'b0;
                end
                for (int l = 0; l < spsq_pkg::NUM_LEVELS; l++)
                begin
                    if (!found && (eff_cnt[l] != '0))
                    begin
                        found = 1'b1;
                        sel   = spsq_pkg::LVL_W'(l);
                    end
                end
            end
            if (found)
            begin
                grant_valid_next = 1'b1;
                grant_level_next = sel;
                status_next      = spsq_pkg::ST_GRANT;
                level_next       = sel;
                use_id_next      = 1'b1;
                rd_lvl           = sel;
            end
            else
            begin
                grant_valid_next = 1'b0;
                status_next      = spsq_pkg::ST_IDLE;
            end
        end

        mem_raddr = addr_of(rd_lvl, eff_head[rd_lvl]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < spsq_pkg::NUM_LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
            resume_valid_reg <= 1'b0;
            resume_level_reg <= '0;
            grant_valid_reg  <= 1'b0;
            grant_level_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            cnt_reg          <= cnt_next;
            resume_valid_reg <= resume_valid_next;
            resume_level_reg <= resume_level_next;
            grant_valid_reg  <= grant_valid_next;
            grant_level_reg  <= grant_level_next;
        end
    end

    // Payload registers: request capture, result and queue memory
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            level_reg   <= level_next;
            use_id_reg  <= use_id_next;
            rd_data_reg <= mem[mem_raddr];
            if (mem_we)
            begin
                mem[mem_waddr] <= req_reg.package_id;
            end
        end
    end

    assign result.status        = status_reg;
    assign result.granted_id    = use_id_reg ? rd_data_reg : '0;
    assign result.granted_level = level_reg;

endmodule

@@ dv/spsq_grant_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsq_grant_checker
// Watches the request and result channels of the strict-priority send queue
// scheduler, keeps its own copy of the per-level FIFOs, resume and grant
// state, predicts the answer to each accepted transaction and compares every
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module spsq_grant_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  spsq_pkg::req_t  request,
    input  logic            result_valid,
    input  spsq_pkg::rsp_t  result,
    output int              mismatches,
    output int              outstanding
);

    import spsq_pkg::*;

    logic [ID_W-1:0]  id_store [MEM_DEPTH];
    logic [PTR_W-1:0] head_idx [NUM_LEVELS];
    logic [PTR_W-1:0] tail_idx [NUM_LEVELS];
    logic [CNT_W-1:0] level_fill [NUM_LEVELS];
    logic             resume_valid;
    logic [LVL_W-1:0] resume_level;
    logic             grant_valid;
    logic [LVL_W-1:0] grant_level;

    rsp_t scheduler_answers [$];
    int   mismatch_count = 0;
    int   answers_waiting = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = answers_waiting;

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [PTR_W-1:0] advance_idx(input logic [PTR_W-1:0] p);
        return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ID_W-1:0] head_id(input logic [LVL_W-1:0] lvl);
        return id_store[int'(lvl) * QUEUE_DEPTH + int'(head_idx[lvl])];
    endfunction

    // Resume level first, then the highest non-empty level, else idle.
    task automatic grant_next(output rsp_t ans);
        int lvl;
        bit found;
        ans   = '0;
        found = 1'b0;
        if (resume_valid) begin
            if (int'(resume_level) < NUM_LEVELS && level_fill[resume_level] != 0) begin
                grant_valid       = 1'b1;
                grant_level       = resume_level;
                ans.status        = ST_GRANT;
                ans.granted_id    = head_id(resume_level);
                ans.granted_level = resume_level;
                found             = 1'b1;
            end
            else begin
                resume_valid = 1'b0;
            end
        end
        for (lvl = 0; lvl < NUM_LEVELS; lvl++) begin
            if (!found && level_fill[lvl] != 0) begin
                grant_valid       = 1'b1;
                grant_level       = LVL_W'(lvl);
                ans.status        = ST_GRANT;
                ans.granted_id    = head_id(LVL_W'(lvl));
                ans.granted_level = LVL_W'(lvl);
                found             = 1'b1;
            end
        end
        if (!found) begin
            grant_valid = 1'b0;
            ans.status  = ST_IDLE;
        end
    endtask

    task automatic schedule_step(input req_t r, output rsp_t ans);
        logic [LVL_W-1:0] lvl;
        ans = '0;
        lvl = r.priority_req;
        if (r.req_type == REQ_ENQUEUE) begin
            if (int'(lvl) >= NUM_LEVELS) begin
                ans.status = ST_ERROR;
            end
            else if (int'(level_fill[lvl]) >= QUEUE_DEPTH) begin
                ans.status = ST_FULL;
            end
            else begin
                id_store[int'(lvl) * QUEUE_DEPTH + int'(tail_idx[lvl])] = r.package_id;
                tail_idx[lvl]   = advance_idx(tail_idx[lvl]);
                level_fill[lvl] = level_fill[lvl] + 1'b1;
                ans.status      = ST_ACCEPTED;
            end
        end
        else if (r.req_type == REQ_OFFER) begin
            grant_next(ans);
        end
        else if (r.req_type == REQ_OUTCOME) begin
            if (!grant_valid || int'(grant_level) >= NUM_LEVELS
                || level_fill[grant_level] == 0) begin
                ans.status = ST_ERROR;
            end
            else if (r.send_outcome == OUT_DONE) begin
                head_idx[grant_level]   = advance_idx(head_idx[grant_level]);
                level_fill[grant_level] = level_fill[grant_level] - 1'b1;
                resume_valid            = 1'b0;
                grant_valid             = 1'b0;
                grant_next(ans);
            end
            else if (r.send_outcome == OUT_PARTIAL) begin
                resume_valid      = 1'b1;
                resume_level      = grant_level;
                grant_valid       = 1'b0;
                ans.status        = ST_RETRY;
                ans.granted_id    = head_id(grant_level);
                ans.granted_level = grant_level;
            end
            else begin
                ans.status = ST_ERROR;
            end
        end
        else begin
            ans.status = ST_ERROR;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        rsp_t fresh;
        rsp_t want;
        if (!rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_idx[i]   = '0;
                tail_idx[i]   = '0;
                level_fill[i] = '0;
            end
            resume_valid = 1'b0;
            resume_level = '0;
            grant_valid  = 1'b0;
            grant_level  = '0;
            scheduler_answers.delete();
            answers_waiting = 0;
        end
        else begin
            if (start && !busy) begin
                schedule_step(request, fresh);
                scheduler_answers.push_back(fresh);
            end
            if (result_valid) begin
                if (scheduler_answers.size() == 0) begin
                    report_mismatch($sformatf("result with nothing outstanding (status %0d)",
                                              result.status));
                end
                else begin
                    want = scheduler_answers.pop_front();
                    if (result.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  result.status, want.status));
                    if (result.granted_id !== want.granted_id)
                        report_mismatch($sformatf("granted_id 0x%04h, expected 0x%04h",
                                                  result.granted_id, want.granted_id));
                    if (result.granted_level !== want.granted_level)
                        report_mismatch($sformatf("granted_level %0d, expected %0d",
                                                  result.granted_level, want.granted_level));
                end
            end
            answers_waiting = scheduler_answers.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the strict-priority send queue scheduler.
// ----------------------------------------------------------------------------
// Drive a short directed sequence through every request type, outcome code and
// corner (empty, full, resume, error paths), then bursty random traffic in
// three phases of sender idling. The checker beside the block predicts and
// compares each result; this module only supplies transactions and reports.
// ----------------------------------------------------------------------------
module testbench;

    import spsq_pkg::*;

    // Codes the block must reject; the package leaves them unnamed.
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam logic [1:0] OUT_ERROR   = 2'd2;
    localparam logic [1:0] OUT_UNKNOWN = 2'd3;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int ITEMS_PER_PASS = 467;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t request = '0;
    logic result_valid;
    rsp_t result;

    int mismatches;
    int outstanding;
    int cycle_count     = 0;
    int sender_idle_pct = 0;
    int items_sent      = 0;

    always #2 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    strict_priority_send_queues_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    spsq_grant_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    function automatic req_t pack_request(input logic [1:0] kind, input logic [15:0] id,
                                          input logic [1:0] lvl, input logic [1:0] outcome);
        req_t r;
        r.req_type     = kind;
        r.package_id   = id;
        r.priority_req = lvl;
        r.send_outcome = outcome;
        return r;
    endfunction

    // Hand one transaction to the block. Idle first at the current rate, with
    // junk on the request bus, then hold start until busy is seen low at an
    // edge. start stays high on return so that back-to-back transactions need
    // no second assignment in the same step.
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < sender_idle_pct) begin
            start   <= 1'b0;
            request <= req_t'($urandom);
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent++;
    endtask

    // One outcome report with a code weighted towards done.
    function automatic logic [1:0] pick_outcome();
        int w;
        w = $urandom_range(99);
        if (w < 55) return OUT_DONE;
        if (w < 85) return OUT_PARTIAL;
        return (w < 93) ? OUT_ERROR : OUT_UNKNOWN;
    endfunction

    // Mostly well-formed traffic: fill bursts that can reach a full level, drain
    // runs of offer plus mostly done reports, and single weighted transactions;
    // a share of the traffic is raw noise on every field.
    task automatic run_traffic(input int count);
        int goal;
        int pick;
        int w;
        int n;
        logic [1:0] lvl;
        logic [1:0] outcome;
        goal = items_sent + count;
        while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                lvl = 2'($urandom_range(3));
                n   = $urandom_range(20, 12);
                repeat (n) send_request(pack_request(REQ_ENQUEUE, 16'($urandom), lvl,
                                                     2'($urandom)));
            end
            else if (pick < 20) begin
                send_request(pack_request(REQ_OFFER, 16'($urandom), 2'($urandom),
                                          2'($urandom)));
                n = $urandom_range(18, 1);
                repeat (n) begin
                    outcome = ($urandom_range(99) < 85) ? OUT_DONE : OUT_PARTIAL;
                    send_request(pack_request(REQ_OUTCOME, 16'($urandom), 2'($urandom),
                                              outcome));
                    // re-offer after a partial report so the run carries on
                    if (outcome == OUT_PARTIAL)
                        send_request(pack_request(REQ_OFFER, 16'($urandom), 2'($urandom),
                                                  2'($urandom)));
                end
            end
            else if (pick < 28) begin
                send_request(req_t'($urandom));
            end
            else begin
                w = $urandom_range(99);
                if (w < 35)
                    send_request(pack_request(REQ_ENQUEUE, 16'($urandom), 2'($urandom),
                                              2'($urandom)));
                else if (w < 57)
                    send_request(pack_request(REQ_OFFER, 16'($urandom), 2'($urandom),
                                              2'($urandom)));
                else if (w < 94)
                    send_request(pack_request(REQ_OUTCOME, 16'($urandom), 2'($urandom),
                                              pick_outcome()));
                else
                    send_request(pack_request(REQ_UNUSED, 16'($urandom), 2'($urandom),
                                              2'($urandom)));
            end
        end
    endtask

    initial begin
        // Hold reset, once, then release.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: outcome with no grant outstanding, then an unused request type.
        send_request(pack_request(REQ_OUTCOME, 16'h0000, 2'd0, OUT_DONE));
        send_request(pack_request(REQ_UNUSED, 16'hFFFF, 2'd3, OUT_UNKNOWN));
        // Grant level 1, report partial, then check the resume level wins over
        // a newly queued level 0 entry.
        send_request(pack_request(REQ_ENQUEUE, 16'hFFFF, 2'd1, OUT_DONE));
        send_request(pack_request(REQ_OFFER, 16'h0000, 2'd0, OUT_DONE));
        send_request(pack_request(REQ_OUTCOME, 16'h0000, 2'd0, OUT_PARTIAL));
        send_request(pack_request(REQ_ENQUEUE, 16'h0000, 2'd0, OUT_DONE));
        send_request(pack_request(REQ_OFFER, 16'hFFFF, 2'd3, OUT_UNKNOWN));
        // Send error and unknown outcome codes leave the grant in place.
        send_request(pack_request(REQ_OUTCOME, 16'h0000, 2'd0, OUT_ERROR));
        send_request(pack_request(REQ_OUTCOME, 16'h0000, 2'd0, OUT_UNKNOWN));
        // Done pops level 1 and grants level 0; done again drains to idle.
        send_request(pack_request(REQ_OUTCOME, 16'h0000, 2'd0, OUT_DONE));
        send_request(pack_request(REQ_OUTCOME, 16'hFFFF, 2'd3, OUT_DONE));
        // Fill level 3 to the brim, then one more for the full answer.
        send_request(pack_request(REQ_ENQUEUE, 16'hAAAA, 2'd3, OUT_DONE));
        send_request(pack_request(REQ_ENQUEUE, 16'h5555, 2'd3, OUT_DONE));
        repeat (QUEUE_DEPTH - 2)
            send_request(pack_request(REQ_ENQUEUE, 16'($urandom), 2'd3, OUT_DONE));
        send_request(pack_request(REQ_ENQUEUE, 16'h1234, 2'd3, OUT_DONE));

        // Random traffic: moderate sender gaps, heavy gaps, then none.
        sender_idle_pct = 38;
        run_traffic(ITEMS_PER_PASS);
        sender_idle_pct = 60;
        run_traffic(ITEMS_PER_PASS);
        sender_idle_pct = 0;
        run_traffic(ITEMS_PER_PASS);

        // Drop start and wait for every outstanding answer, then idle for DRAIN_CYCLES
        // more to catch anything stray.
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("** strict_priority_send_queues_top: PASSED **");
        else
            $display("** strict_priority_send_queues_top: FAILED **");
        $finish;
    end

    // Watchdog: end the run if the traffic never completes.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("** strict_priority_send_queues_top: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/spsq_pkg.sv
rtl/spsq_ctrl.sv
rtl/spsq_datapath.sv
rtl/strict_priority_send_queues_top.sv
dv/spsq_grant_checker.sv
dv/testbench.sv
